FILE: hdl/assert_macros.svh
// Assertion macros shared by the terminal writer RTL.
// Included by the top level, which writes its concurrent checks with them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TMTW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TMTW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tmtw_pkg.sv
// Shared types and constants of the text-mode terminal writer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package tmtw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CELL_W     = 16;
    localparam int CUR_COL_W  = 7;
    localparam int CUR_ROW_W  = 5;
    localparam int CUR_POS_W  = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Operation codes.
    localparam logic [1:0] FUNC_PUT  = 2'd0;
    localparam logic [1:0] FUNC_SET  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // Control characters.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;

    // A cell keeps the attribute in the upper byte, the character in the lower.
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

    localparam logic [3:0] FG_RESET = 4'hF;
    localparam logic [3:0] BG_RESET = 4'h0;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [7:0]  set_col;
        logic [4:0]  set_row;
        logic [10:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0]           cell_char;
        logic [7:0]           cell_attr;
        logic [CUR_COL_W-1:0] cur_col;
        logic [CUR_ROW_W-1:0] cur_row;
        logic [CUR_POS_W-1:0] cur_pos;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic sweep_start;
        logic sweep_clear;
        logic load_result;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scroll;
        logic sweep_busy;
    } dp_status_t;

endpackage

FILE: hdl/tmtw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the screen cells of the terminal writer.
`timescale 1ns / 1ps

module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/tmtw_ctrl.sv
// Sequencing state machine of the terminal writer: handshakes and commands.
// Depends on tmtw_pkg for the command and status structs.
`timescale 1ns / 1ps

module tmtw_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  tmtw_pkg::dp_status_t   status,
    output tmtw_pkg::ctrl_cmd_t    cmd
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_IDLE   = 3'd2;
    localparam logic [2:0] ST_EXEC   = 3'd3;
    localparam logic [2:0] ST_SWEEP  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_clear = 1'b1;
                state_next      = ST_CLEAR;
            end
            ST_CLEAR: begin
                if (!status.sweep_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.need_scroll) begin
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SWEEP;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_SWEEP: begin
                if (!status.sweep_busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // The result waits here until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: hdl/tmtw_datapath.sv
// Datapath of the terminal writer: cursor, colours, screen RAM and sweep engine.
// Depends on tmtw_pkg and instantiates tmtw_ram.
`timescale 1ns / 1ps

module tmtw_datapath #(
    parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tmtw_pkg::ctrl_cmd_t                 cmd,
    output tmtw_pkg::dp_status_t                status,
    input  tmtw_pkg::in_item_t                  s_item,
    output tmtw_pkg::out_item_t                 m_item,
    input  logic                                cfg_valid,
    input  logic [tmtw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmtw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int MOVE   = COLUMNS * (ROWS - 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = tmtw_pkg::CELL_W;
    localparam int OCOL_W = tmtw_pkg::CUR_COL_W;
    localparam int OROW_W = tmtw_pkg::CUR_ROW_W;
    localparam int OPOS_W = tmtw_pkg::CUR_POS_W;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] CNT_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);

    tmtw_pkg::in_item_t  item_reg, item_next;
    tmtw_pkg::out_item_t out_reg, out_next;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [3:0]        fg_reg, fg_next;
    logic [3:0]        bg_reg, bg_next;
    logic              read_hit_reg, read_hit_next;

    logic              swp_active_reg, swp_active_next;
    logic              swp_clear_reg, swp_clear_next;
    logic [ADDR_W-1:0] swp_cnt_reg, swp_cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              pend_blank_reg, pend_blank_next;

    logic [COL_W-1:0]  op_col;
    logic [ROW_W-1:0]  op_row;
    logic              op_scroll;
    logic              op_write;
    logic [COL_W-1:0]  wr_col;
    logic [ROW_W-1:0]  wr_row;
    logic [7:0]        wr_char;
    logic [ROW_W-1:0]  set_row_sat;
    logic              set_col_wrap;
    logic              rd_in_range;
    logic              exec_read;
    logic              swp_move;
    logic [ADDR_W-1:0] wr_lin;
    logic [ADDR_W-1:0] cur_lin;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    assign set_row_sat  = (32'(item_reg.set_row) >= ROWS) ? ROW_LAST
                                                          : ROW_W'(item_reg.set_row);
    assign set_col_wrap = (32'(item_reg.set_col) >= COLUMNS);
    assign rd_in_range  = (32'(item_reg.read_index) < CELLS);

    // Cursor update and cell write of the latched operation.
    always_comb begin
        op_col    = col_reg;
        op_row    = row_reg;
        op_scroll = 1'b0;
        op_write  = 1'b0;
        wr_col    = col_reg;
        wr_row    = row_reg;
        wr_char   = item_reg.char_code;
        case (item_reg.func)
            tmtw_pkg::FUNC_PUT: begin
                case (item_reg.char_code)
                    tmtw_pkg::CH_NEWLINE: begin
                        op_col = '0;
                        if (row_reg == ROW_LAST) begin
                            op_scroll = 1'b1;
                        end else begin
                            op_row = row_reg + 1'b1;
                        end
                    end
                    tmtw_pkg::CH_RETURN: begin
                        op_col = '0;
                    end
                    tmtw_pkg::CH_BACKSPACE: begin
                        if (col_reg != '0) begin
                            op_col = col_reg - 1'b1;
                        end else if (row_reg != '0) begin
                            op_row = row_reg - 1'b1;
                        end
                        wr_col   = op_col;
                        wr_row   = op_row;
                        wr_char  = tmtw_pkg::BLANK_CHAR;
                        op_write = 1'b1;
                    end
                    default: begin
                        op_write = 1'b1;
                        if (col_reg == COL_LAST) begin
                            op_col = '0;
                            if (row_reg == ROW_LAST) begin
                                op_scroll = 1'b1;
                            end else begin
                                op_row = row_reg + 1'b1;
                            end
                        end else begin
                            op_col = col_reg + 1'b1;
                        end
                    end
                endcase
            end
            tmtw_pkg::FUNC_SET: begin
                op_row = set_row_sat;
                op_col = COL_W'(item_reg.set_col);
                if (set_col_wrap) begin
                    op_col = '0;
                    if (set_row_sat == ROW_LAST) begin
                        op_scroll = 1'b1;
                    end else begin
                        op_row = set_row_sat + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign wr_lin    = ADDR_W'(wr_row) * ROW_SPAN + ADDR_W'(wr_col);
    assign cur_lin   = ADDR_W'(row_reg) * ROW_SPAN + ADDR_W'(col_reg);
    assign exec_read = cmd.exec && (item_reg.func == tmtw_pkg::FUNC_READ) && rd_in_range;

    // The sweep reads the cell one row below and writes it in the following cycle;
    // cells past the moved region, and every cell when clearing, get blanks.
    assign swp_move = !swp_clear_reg && (32'(swp_cnt_reg) < MOVE);

    always_comb begin
        swp_active_next = swp_active_reg;
        swp_clear_next  = swp_clear_reg;
        swp_cnt_next    = swp_cnt_reg;
        if (cmd.sweep_start) begin
            swp_active_next = 1'b1;
            swp_clear_next  = cmd.sweep_clear;
            swp_cnt_next    = '0;
        end else if (swp_active_reg) begin
            swp_cnt_next = swp_cnt_reg + 1'b1;
            if (swp_cnt_reg == CNT_LAST) begin
                swp_active_next = 1'b0;
            end
        end
        pend_valid_next = swp_active_reg;
        pend_addr_next  = swp_cnt_reg;
        pend_blank_next = !swp_move;
    end

    assign ram_we      = pend_valid_reg || (cmd.exec && op_write);
    assign ram_wr_addr = pend_valid_reg ? pend_addr_reg : wr_lin;
    assign ram_wr_data = pend_valid_reg ? (pend_blank_reg ? tmtw_pkg::BLANK_CELL : ram_rd_data)
                                        : {bg_reg, fg_reg, wr_char};
    assign ram_rd_en   = (swp_active_reg && swp_move) || exec_read;
    assign ram_rd_addr = swp_active_reg ? (swp_cnt_reg + ROW_SPAN)
                                        : ADDR_W'(item_reg.read_index);

    tmtw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        item_next     = item_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        read_hit_next = read_hit_reg;
        out_next      = out_reg;
        if (cmd.load_item) begin
            item_next = s_item;
        end
        if (cmd.exec) begin
            col_next      = op_col;
            row_next      = op_row;
            read_hit_next = exec_read;
        end
        if (cfg_valid) begin
            case (cfg_index)
                tmtw_pkg::CFG_FG: fg_next = cfg_data;
                tmtw_pkg::CFG_BG: bg_next = cfg_data;
                default: begin
                end
            endcase
        end
        if (cmd.load_result) begin
            out_next.cell_char = read_hit_reg ? ram_rd_data[7:0] : 8'h00;
            out_next.cell_attr = read_hit_reg ? ram_rd_data[15:8] : 8'h00;
            out_next.cur_col   = OCOL_W'(col_reg);
            out_next.cur_row   = OROW_W'(row_reg);
            out_next.cur_pos   = OPOS_W'(cur_lin);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            fg_reg         <= tmtw_pkg::FG_RESET;
            bg_reg         <= tmtw_pkg::BG_RESET;
            swp_active_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            fg_reg         <= fg_next;
            bg_reg         <= bg_next;
            swp_active_reg <= swp_active_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        out_reg        <= out_next;
        read_hit_reg   <= read_hit_next;
        swp_clear_reg  <= swp_clear_next;
        swp_cnt_reg    <= swp_cnt_next;
        pend_addr_reg  <= pend_addr_next;
        pend_blank_reg <= pend_blank_next;
    end

    assign status.need_scroll = op_scroll;
    assign status.sweep_busy  = swp_active_reg || pend_valid_reg;
    assign m_item             = out_reg;

endmodule

FILE: hdl/text_mode_terminal_writer_core.sv
// Text-mode terminal writer: an item goes from acceptance to its result through
// the steps accept, execute and load output; one item is in work at a time, so a
// new item is taken only once the last one is done. A scroll adds a sweep through
// the one-write, one-read screen RAM. After reset a start state and a clearing pass
// hold off input while the screen is blanked.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_mode_terminal_writer_core #(
    parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tmtw_pkg::in_item_t               s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tmtw_pkg::out_item_t              m_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tmtw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmtw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    tmtw_pkg::ctrl_cmd_t  cmd;
    tmtw_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    tmtw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tmtw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_item    (s_item),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // An item is never taken while the screen sweep still owns the RAM.
    `TMTW_ASSERT_NOW(a_no_accept_in_sweep, aclk, aresetn, s_ready, !status.sweep_busy, "item accepted during sweep")

    // A sweep is only started from an idle sweep engine.
    `TMTW_ASSERT_NOW(a_sweep_start_idle, aclk, aresetn, cmd.sweep_start, !status.sweep_busy, "sweep restarted while busy")

    // A result is loaded only when the output register is free or draining.
    `TMTW_ASSERT_NOW(a_result_slot_free, aclk, aresetn, cmd.load_result, (!m_valid || m_ready), "result overwrote a pending item")

    // An accepted item is executed in the following cycle.
    `TMTW_ASSERT_NEXT(a_accept_then_exec, aclk, aresetn, (s_valid && s_ready), cmd.exec, "accepted item not executed")

endmodule
